### rtl/rpia_pkg.sv
`default_nettype none
package rpia_pkg;

    // fixed field widths
    localparam int COORD_BITS = 12;
    localparam int TIDX_W     = 10;
    localparam int VAL_W      = 32;
    localparam int CIDX_W     = 3;
    localparam int CDATA_W    = 24;
    localparam int DX_W       = COORD_BITS + 10;
    localparam int R2_W       = 2 * DX_W;
    localparam int ROOT_W     = DX_W;
    localparam int SQ_ITER    = R2_W / 2;
    localparam int SQ_STG     = SQ_ITER / 2;

    // item operations
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_BIN_WIDTH     = 3'd2,
        CFG_INV_BIN_WIDTH = 3'd3,
        CFG_ACTIVE_BINS   = 3'd4,
        CFG_IMAGE_WIDTH   = 3'd5,
        CFG_IMAGE_HEIGHT  = 3'd6
    } t_cfg_idx;

    // square root working pair
    typedef struct packed {
        logic [R2_W-1:0] rem;
        logic [R2_W-1:0] root;
    } t_sq;

    // item fields carried down the pipeline
    typedef struct packed {
        logic                  op;
        logic [TIDX_W-1:0]     idx;
        logic [VAL_W-1:0]      tval;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [VAL_W-1:0]      pv;
        logic                  in_box;
    } t_carry;

    // one restoring square root step, k counts from the top digit
    function automatic t_sq sq_step(input t_sq s, input int unsigned k);
        logic [R2_W-1:0] b;
        logic [R2_W-1:0] t;
        t_sq r;
        b = R2_W'(1) << (R2_W - 2 - 2 * k);
        t = s.root + b;
        if (s.rem >= t) begin
            r.rem  = s.rem - t;
            r.root = (s.root >> 1) + b;
        end else begin
            r.rem  = s.rem;
            r.root = s.root >> 1;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/rpia_if.sv
`default_nettype none
// pixel and load item channel
interface rpia_in_if import rpia_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [TIDX_W-1:0]     table_index;
    logic [VAL_W-1:0]      table_value;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [VAL_W-1:0]      pixel_value;
    modport source (output valid, operation, table_index, table_value,
                    pixel_x, pixel_y, pixel_value, input ready);
    modport sink   (input valid, operation, table_index, table_value,
                    pixel_x, pixel_y, pixel_value, output ready);
endinterface

// result item channel
interface rpia_out_if import rpia_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [VAL_W-1:0]      new_value;
    logic                  inside_box;
    modport source (output valid, out_x, out_y, new_value, inside_box, input ready);
    modport sink   (input valid, out_x, out_y, new_value, inside_box, output ready);
endinterface

// configuration write channel
interface rpia_cfg_if import rpia_pkg::*;;
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  index;
    logic [CDATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/radial_profile_image_accumulator.sv
// Radial profile image accumulator.
// i_pix takes load items (operation 0), which write one profile table entry and
// give no result, and pixel items (operation 1), which give one result on o_res:
// the echoed coordinates, the pixel value plus the interpolated profile
// (saturated) inside the box or else the pixel value unchanged, and the
// inside-box flag. i_cfg writes the seven registers, always ready, and must
// be used only while no item is in flight; the block does not enforce this.
// Throughput: one item per cycle while o_res is not stalled; the pipeline is
// 19 register stages, the square root taking eleven of them at two digits
// each, and the table is read at two addresses in one stage with a load
// written in that same stage, so loads and pixels keep their order.
// The whole pipeline advances together whenever the output register is empty
// or being taken; while o_res is stalled with a result held, i_pix.ready is low
// and every stage holds its item.
// Reset (synchronous, active low) clears all valid bits and restores the
// register defaults; the profile table is not cleared and must be loaded
// before the entries in use are read.
`default_nettype none
module radial_profile_image_accumulator import rpia_pkg::*; #(
    parameter int MAX_BINS = 1024
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    rpia_cfg_if.sink        i_cfg,
    rpia_in_if.sink         i_pix,
    rpia_out_if.source      o_res
);

    localparam int ADDR_W = $clog2(MAX_BINS);
    localparam int NB_W   = $clog2(MAX_BINS + 1);
    localparam int EXT_W  = 16 + NB_W;
    localparam int S_W    = ((EXT_W > 21) ? EXT_W : 21) + 2;
    localparam int IW     = (ADDR_W > TIDX_W) ? ADDR_W : TIDX_W;
    localparam int PR_W   = ROOT_W + 24;

    // configuration registers
    logic signed [20:0] r_cx, r_cy;
    logic [15:0]        r_bw;
    logic [23:0]        r_ibw;
    logic [10:0]        r_ab;
    logic [12:0]        r_iw, r_ih;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx  <= '0;
            r_cy  <= '0;
            r_bw  <= 16'd256;
            r_ibw <= 24'd65536;
            r_ab  <= 11'd1;
            r_iw  <= 13'd4096;
            r_ih  <= 13'd4096;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_CENTER_X:      r_cx  <= i_cfg.data[20:0];
                CFG_CENTER_Y:      r_cy  <= i_cfg.data[20:0];
                CFG_BIN_WIDTH:     r_bw  <= i_cfg.data[15:0];
                CFG_INV_BIN_WIDTH: r_ibw <= i_cfg.data[23:0];
                CFG_ACTIVE_BINS:   r_ab  <= i_cfg.data[10:0];
                CFG_IMAGE_WIDTH:   r_iw  <= i_cfg.data[12:0];
                CFG_IMAGE_HEIGHT:  r_ih  <= i_cfg.data[12:0];
                default: ;
            endcase
        end
    end

    // clamped bin count and last bin
    logic [NB_W-1:0]   w_nb;
    logic [ADDR_W-1:0] w_last;
    always_comb begin
        if (r_ab == '0) begin
            w_nb = NB_W'(1);
        end else if (32'(r_ab) > MAX_BINS) begin
            w_nb = NB_W'(MAX_BINS);
        end else begin
            w_nb = NB_W'(r_ab);
        end
        w_last = ADDR_W'(w_nb - NB_W'(1));
    end

    // pipeline advance
    logic r_o_v;
    logic w_en;
    assign w_en        = !r_o_v || o_res.ready;
    assign i_pix.ready = w_en;

    // stage 1: offsets from centre and box extent
    logic                  r1_v;
    t_carry                r1_c;
    logic signed [DX_W-1:0] r1_dx, r1_dy;
    logic [EXT_W-1:0]      r1_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_c.op     <= i_pix.operation;
            r1_c.idx    <= i_pix.table_index;
            r1_c.tval   <= i_pix.table_value;
            r1_c.px     <= i_pix.pixel_x;
            r1_c.py     <= i_pix.pixel_y;
            r1_c.pv     <= i_pix.pixel_value;
            r1_c.in_box <= 1'b0;
            r1_dx  <= $signed({2'b00, i_pix.pixel_x, 8'h00})
                    - $signed({{(DX_W-21){r_cx[20]}}, r_cx});
            r1_dy  <= $signed({2'b00, i_pix.pixel_y, 8'h00})
                    - $signed({{(DX_W-21){r_cy[20]}}, r_cy});
            r1_ext <= EXT_W'(r_bw * w_nb);
        end
    end

    // stage 2: box edges and squared offsets
    function automatic logic signed [S_W-1:0] trunc8(input logic signed [S_W-1:0] v);
        logic signed [S_W-1:0] n;
        n = -v;
        if (v[S_W-1]) begin
            return -(n >>> 8);
        end
        return v >>> 8;
    endfunction

    logic signed [S_W-1:0] w_cxs, w_cys, w_exs;
    logic signed [S_W-1:0] w_x1, w_x2, w_y1, w_y2, w_xl, w_yl;
    always_comb begin
        w_cxs = S_W'(r_cx);
        w_cys = S_W'(r_cy);
        w_exs = $signed({{(S_W-EXT_W){1'b0}}, r1_ext});
        w_xl  = $signed({{(S_W-13){1'b0}}, r_iw}) - S_W'(1);
        w_yl  = $signed({{(S_W-13){1'b0}}, r_ih}) - S_W'(1);
        w_x1  = trunc8(w_cxs - w_exs);
        w_x2  = trunc8(w_cxs + w_exs);
        w_y1  = trunc8(w_cys - w_exs);
        w_y2  = trunc8(w_cys + w_exs);
        if (w_x1 < 0) begin
            w_x1 = '0;
        end
        if (w_y1 < 0) begin
            w_y1 = '0;
        end
        if (w_x2 > w_xl) begin
            w_x2 = w_xl;
        end
        if (w_y2 > w_yl) begin
            w_y2 = w_yl;
        end
    end

    logic                  r2_v;
    t_carry                r2_c;
    logic signed [S_W-1:0] r2_x1, r2_x2, r2_y1, r2_y2;
    logic [R2_W-1:0]       r2_dx2, r2_dy2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c   <= r1_c;
            r2_x1  <= w_x1;
            r2_x2  <= w_x2;
            r2_y1  <= w_y1;
            r2_y2  <= w_y2;
            r2_dx2 <= R2_W'(r1_dx * r1_dx);
            r2_dy2 <= R2_W'(r1_dy * r1_dy);
        end
    end

    // stage 3: box test and squared radius, feeds the root pipeline
    logic signed [S_W-1:0] w_pxs, w_pys;
    assign w_pxs = $signed({{(S_W-COORD_BITS){1'b0}}, r2_c.px});
    assign w_pys = $signed({{(S_W-COORD_BITS){1'b0}}, r2_c.py});

    t_carry n_sqc;
    always_comb begin
        n_sqc        = r2_c;
        n_sqc.in_box = (w_pxs >= r2_x1) && (w_pxs <= r2_x2)
                    && (w_pys >= r2_y1) && (w_pys <= r2_y2);
    end

    logic   r_sqv [0:SQ_STG];
    t_carry r_sqc [0:SQ_STG];
    t_sq    r_sqs [0:SQ_STG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv[0] <= 1'b0;
        end else if (w_en) begin
            r_sqv[0] <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sqc[0]      <= n_sqc;
            r_sqs[0].rem  <= r2_dx2 + r2_dy2;
            r_sqs[0].root <= '0;
        end
    end

    // square root: two digits per stage
    for (genvar g = 1; g <= SQ_STG; g++) begin : g_sq
        t_sq n_sq;
        always_comb begin
            n_sq = sq_step(sq_step(r_sqs[g-1], 2 * (g - 1)), 2 * (g - 1) + 1);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqv[g] <= 1'b0;
            end else if (w_en) begin
                r_sqv[g] <= r_sqv[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sqc[g] <= r_sqc[g-1];
                r_sqs[g] <= n_sq;
            end
        end
    end

    // radius times inverse bin width
    logic            rm_v;
    t_carry          rm_c;
    logic [PR_W-1:0] rm_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (w_en) begin
            rm_v <= r_sqv[SQ_STG];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_c    <= r_sqc[SQ_STG];
            rm_prod <= r_sqs[SQ_STG].root[ROOT_W-1:0] * r_ibw;
        end
    end

    // bin indices and weight
    logic [PR_W-25:0]  w_bin;
    logic [ADDR_W-1:0] w_i0, w_i1;
    always_comb begin
        w_bin = rm_prod[PR_W-1:24];
        if (32'(w_bin) >= 32'(w_nb)) begin
            w_i0 = w_last;
        end else begin
            w_i0 = ADDR_W'(w_bin);
        end
        if (32'(w_i0) + 32'd1 > 32'(w_last)) begin
            w_i1 = w_last;
        end else begin
            w_i1 = w_i0 + ADDR_W'(1);
        end
    end

    logic              ri_v;
    t_carry            ri_c;
    logic [ADDR_W-1:0] ri_a0, ri_a1;
    logic [15:0]       ri_w1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ri_v <= 1'b0;
        end else if (w_en) begin
            ri_v <= rm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            ri_c  <= rm_c;
            ri_a0 <= w_i0;
            ri_a1 <= w_i1;
            ri_w1 <= rm_prod[23:8];
        end
    end

    // profile table: loads write here, pixels read both entries here
    logic [VAL_W-1:0] r_mem [0:MAX_BINS-1];
    logic [IW-1:0]    w_widx;
    logic             w_wr;
    assign w_widx = IW'(ri_c.idx);
    assign w_wr   = w_en && ri_v && (ri_c.op == OP_LOAD) && (32'(ri_c.idx) < MAX_BINS);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[ADDR_W'(w_widx)] <= ri_c.tval;
        end
    end

    logic             rr_v;
    t_carry           rr_c;
    logic [15:0]      rr_w1;
    logic [VAL_W-1:0] rr_d0, rr_d1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rr_v <= 1'b0;
        end else if (w_en) begin
            rr_v <= ri_v && (ri_c.op == OP_PIXEL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rr_c  <= ri_c;
            rr_w1 <= ri_w1;
            rr_d0 <= r_mem[ri_a0];
            rr_d1 <= r_mem[ri_a1];
        end
    end

    // weighted entries
    logic               rw_v;
    t_carry             rw_c;
    logic signed [49:0] rw_p0, rw_p1;
    logic [16:0]        w_w0;
    assign w_w0 = 17'h10000 - {1'b0, rr_w1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rw_v <= 1'b0;
        end else if (w_en) begin
            rw_v <= rr_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rw_c  <= rr_c;
            rw_p0 <= $signed(rr_d0) * $signed({1'b0, w_w0});
            rw_p1 <= $signed(rr_d1) * $signed({2'b00, rr_w1});
        end
    end

    // sum, add to pixel and saturate
    logic signed [50:0] w_val;
    logic signed [35:0] w_sum;
    logic [VAL_W-1:0]   w_new;
    always_comb begin
        w_val = 51'(rw_p0) + 51'(rw_p1);
        w_sum = 36'(w_val >>> 16) + 36'($signed(rw_c.pv));
        if (w_sum > 36'sh07FFFFFFF) begin
            w_new = 32'h7FFFFFFF;
        end else if (w_sum < -36'sh080000000) begin
            w_new = 32'h80000000;
        end else begin
            w_new = w_sum[31:0];
        end
    end

    logic [COORD_BITS-1:0] r_o_x, r_o_y;
    logic [VAL_W-1:0]      r_o_val;
    logic                  r_o_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r_o_v <= rw_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_x   <= rw_c.px;
            r_o_y   <= rw_c.py;
            r_o_in  <= rw_c.in_box;
            r_o_val <= rw_c.in_box ? w_new : rw_c.pv;
        end
    end

    assign o_res.valid      = r_o_v;
    assign o_res.out_x      = r_o_x;
    assign o_res.out_y      = r_o_y;
    assign o_res.new_value  = r_o_val;
    assign o_res.inside_box = r_o_in;

endmodule
`default_nettype wire
